FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked outside reset.
`define PCLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define PCLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCLB_ASSERT(lbl, prop, msg)
`define PCLB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/pclb_pkg.sv
package pclb_pkg;

  typedef enum logic [2:0] {
    K_INSERT = 3'd0,
    K_REMOVE = 3'd1,
    K_LOOKUP = 3'd2,
    K_MOVE   = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_RANGE    = 2'd2,
    ST_PRESENT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH = 2'd0,
    CFG_BIN_COUNT  = 2'd1,
    CFG_CELL_RECIP = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    A_FIN  = 2'd0,
    A_PUSH = 2'd1,
    A_WALK = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_NOP,
    S_GO,
    S_WAITB,
    S_HEAD,
    S_STEP,
    S_ULNK,
    S_PUSH,
    S_PUSHW
  } state_t;

endpackage

FILE: rtl/pclb_bin_calc.sv
module pclb_bin_calc (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [23:0] pos_x,
  input  logic [23:0] pos_y,
  input  logic [31:0] cell_recip,
  input  logic [10:0] grid_width,
  output logic        done,
  output logic [35:0] bin
);

  logic [1:0]  ph;
  logic [23:0] mul_a;
  logic [55:0] prod;
  logic [23:0] cx;
  logic [23:0] cy;
  logic [34:0] cyg;
  logic [34:0] cyg_w;

  // One shared 24x32 multiplier: x in phase one, y in phase two.
  assign mul_a = (ph == 2'd1) ? pos_x : pos_y;
  assign prod  = mul_a * cell_recip;
  assign cyg_w = cy * grid_width;
  assign bin   = {12'b0, cx} + {1'b0, cyg};

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        2'd0: if (go) ph <= 2'd1;
        2'd1: ph <= 2'd2;
        2'd2: ph <= 2'd3;
        2'd3: begin
          ph   <= 2'd0;
          done <= 1'b1;
        end
        default: ph <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph == 2'd1) cx <= prod[55:32];
    if (ph == 2'd2) cy <= prod[55:32];
    if (ph == 2'd3) cyg <= cyg_w;
  end

endmodule

FILE: rtl/particle_cell_list_binning_core.sv
// Insert computes the bin and pushes; remove and lookup compute the bin and walk the chain
// link by link, remove then unlinking the match; move adds an unlink walk and a push.
// Throughput: one operation at a time; busy stays high until the result strobe, and the
// next transfer can land in the strobe cycle.
// Clear sweeps every address of the head and presence memories.
// Reset runs the same sweep with busy high and no result; config writes are taken anyway.
// done marks each result for exactly one cycle; the receiver cannot stall it.
`include "assert_macros.svh"
module particle_cell_list_binning_core #(
  parameter int NUM_BINS      = 1024,
  parameter int NUM_PARTICLES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [9:0]  part_no,
  input  logic [23:0] pos_x,
  input  logic [23:0] pos_y,
  input  logic [9:0]  bin_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic [9:0]  result_bin,
  output logic        found,
  output logic [1:0]  status
);
  import pclb_pkg::*;

  localparam int BW = $clog2(NUM_BINS);
  localparam int PW = $clog2(NUM_PARTICLES);
  localparam int LW = $clog2(NUM_PARTICLES + 1);
  localparam int SW = (NUM_BINS > NUM_PARTICLES) ? NUM_BINS : NUM_PARTICLES;
  localparam int CW = $clog2(SW);
  localparam logic [LW-1:0] CHAIN_END = LW'(NUM_PARTICLES);
  localparam logic [35:0]   NB36      = 36'(NUM_BINS);

  // Config registers.
  logic [10:0] grid_width;
  logic [10:0] bin_count;
  logic [31:0] cell_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 11'd32;
      bin_count  <= 11'd1024;
      cell_recip <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_GRID_WIDTH: grid_width <= cfg_wdata[10:0];
        CFG_BIN_COUNT:  bin_count  <= cfg_wdata[10:0];
        CFG_CELL_RECIP: cell_recip <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Operation registers.
  state_t        state, state_next;
  logic [2:0]    kind_r;
  logic [9:0]    id_r;
  logic [23:0]   pos_x_r;
  logic [23:0]   pos_y_r;
  logic [9:0]    bin_index_r;
  logic [BW-1:0] wb_r;       // chain being walked
  logic [BW-1:0] nb_r;       // chain being pushed onto
  logic [LW-1:0] prev_r;
  logic          first_r;
  logic [CW-1:0] clr_r;
  logic          clr_item_r;

  // Memories and registered read data.
  logic [LW-1:0] heads_mem [NUM_BINS];
  logic [LW-1:0] link_mem  [NUM_PARTICLES];
  logic [BW-1:0] pbin_mem  [NUM_PARTICLES];
  logic          pres_mem  [NUM_PARTICLES];
  logic [LW-1:0] head_rd;
  logic [LW-1:0] link_rd;
  logic [BW-1:0] pbin_rd;
  logic          pres_rd;

  logic          h_we, h_re, l_we, l_re, b_we, p_we, pb_re;
  logic [BW-1:0] h_wa, h_ra;
  logic [LW-1:0] h_wd, l_wd;
  logic [PW-1:0] l_wa, l_ra, b_wa, p_wa;
  logic [BW-1:0] b_wd;
  logic          p_wd;

  // Bin index unit.
  logic        calc_done;
  logic [35:0] calc_bin;

  pclb_bin_calc u_bin_calc (
    .clk       (clk),
    .rst       (rst),
    .go        (state == S_GO),
    .pos_x     (pos_x_r),
    .pos_y     (pos_y_r),
    .cell_recip(cell_recip),
    .grid_width(grid_width),
    .done      (calc_done),
    .bin       (calc_bin)
  );

  // Decision once the bin is known.
  logic [35:0]   lim;
  logic [35:0]   bin_sel;
  logic          oor;
  logic          id_ok;
  logic          pres;
  action_t       act;
  status_t       dec_status;
  logic [9:0]    dec_bin;
  logic [LW-1:0] cur_w;
  logic          walk_end;
  logic          walk_hit;
  logic          clr_last;
  logic          accept;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign lim      = ({25'b0, bin_count} < NB36) ? {25'b0, bin_count} : NB36;
  assign bin_sel  = (kind_t'(kind_r) == K_REMOVE) ? {26'b0, bin_index_r} : calc_bin;
  assign oor      = (bin_sel >= lim);
  assign id_ok    = ({22'b0, id_r} < 32'(NUM_PARTICLES));
  assign pres     = id_ok && pres_rd;
  assign cur_w    = first_r ? head_rd : link_rd;
  assign walk_end = (cur_w >= CHAIN_END);
  assign walk_hit = !walk_end && (cur_w == LW'(id_r));
  assign clr_last = (clr_r == CW'(SW - 1));

  always_comb begin
    act        = A_FIN;
    dec_status = ST_OK;
    dec_bin    = 10'd0;
    case (kind_t'(kind_r))
      K_INSERT: begin
        if (pres) begin
          dec_status = ST_PRESENT;
          dec_bin    = 10'(pbin_rd);
        end else if (oor) begin
          dec_status = ST_RANGE;
        end else if (!id_ok) begin
          dec_status = ST_NOTFOUND;
        end else begin
          act = A_PUSH;
        end
      end
      K_REMOVE, K_LOOKUP: begin
        if (oor) dec_status = ST_RANGE;
        else if (!id_ok) dec_status = ST_NOTFOUND;
        else act = A_WALK;
      end
      K_MOVE: begin
        if (!pres) begin
          dec_status = ST_NOTFOUND;
        end else if (oor) begin
          dec_status = ST_RANGE;
        end else if (36'(pbin_rd) == bin_sel) begin
          dec_bin = 10'(bin_sel);
        end else begin
          act = A_WALK;
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (kind_t'(kind) == K_CLEAR) state_next = S_CLEAR;
          else if (kind <= 3'(K_MOVE)) state_next = S_GO;
          else state_next = S_NOP;
        end
      end
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_NOP:   state_next = S_IDLE;
      S_GO:    state_next = S_WAITB;
      S_WAITB: begin
        if (calc_done) begin
          case (act)
            A_PUSH:  state_next = S_PUSH;
            A_WALK:  state_next = S_HEAD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_HEAD: state_next = S_STEP;
      S_STEP: begin
        if (walk_end) begin
          state_next = (kind_t'(kind_r) == K_MOVE) ? S_PUSH : S_IDLE;
        end else if (walk_hit) begin
          state_next = (kind_t'(kind_r) == K_LOOKUP) ? S_IDLE : S_ULNK;
        end
      end
      S_ULNK:  state_next = (kind_t'(kind_r) == K_REMOVE) ? S_IDLE : S_PUSH;
      S_PUSH:  state_next = S_PUSHW;
      S_PUSHW: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    h_we  = 1'b0;
    h_wa  = wb_r;
    h_wd  = CHAIN_END;
    h_re  = 1'b0;
    h_ra  = wb_r;
    l_we  = 1'b0;
    l_wa  = prev_r[PW-1:0];
    l_wd  = link_rd;
    l_re  = 1'b0;
    l_ra  = cur_w[PW-1:0];
    b_we  = 1'b0;
    b_wa  = PW'(id_r);
    b_wd  = nb_r;
    p_we  = 1'b0;
    p_wa  = PW'(id_r);
    p_wd  = 1'b0;
    pb_re = 1'b0;
    case (state)
      S_CLEAR: begin
        h_we = (32'(clr_r) < 32'(NUM_BINS));
        h_wa = BW'(clr_r);
        p_we = (32'(clr_r) < 32'(NUM_PARTICLES));
        p_wa = PW'(clr_r);
      end
      S_GO:   pb_re = 1'b1;
      S_HEAD: h_re = 1'b1;
      S_STEP: l_re = !walk_end;
      S_ULNK: begin
        // splice out the matched link
        if (prev_r == CHAIN_END) begin
          h_we = 1'b1;
          h_wd = link_rd;
        end else begin
          l_we = 1'b1;
        end
        p_we = (kind_t'(kind_r) == K_REMOVE);
      end
      S_PUSH: begin
        h_re = 1'b1;
        h_ra = nb_r;
      end
      S_PUSHW: begin
        h_we = 1'b1;
        h_wa = nb_r;
        h_wd = LW'(id_r);
        l_we = 1'b1;
        l_wa = PW'(id_r);
        l_wd = head_rd;
        b_we = 1'b1;
        p_we = 1'b1;
        p_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) heads_mem[h_wa] <= h_wd;
    if (h_re) head_rd <= heads_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) link_mem[l_wa] <= l_wd;
    if (l_re) link_rd <= link_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) pbin_mem[b_wa] <= b_wd;
    if (pb_re) pbin_rd <= pbin_mem[PW'(id_r)];
  end

  always_ff @(posedge clk) begin
    if (p_we) pres_mem[p_wa] <= p_wd;
    if (pb_re) pres_rd <= pres_mem[PW'(id_r)];
  end

  // Control state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_r      <= '0;
      clr_item_r <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept && kind_t'(kind) == K_CLEAR) begin
        clr_r      <= '0;
        clr_item_r <= 1'b1;
      end
      if (state == S_CLEAR) begin
        clr_r <= clr_r + CW'(1);
        if (clr_last) done <= clr_item_r;
      end
      if (state_next == S_IDLE && state != S_IDLE && state != S_CLEAR) done <= 1'b1;
    end
  end

  // Operands, walk pointers and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= kind;
      id_r        <= part_no;
      pos_x_r     <= pos_x;
      pos_y_r     <= pos_y;
      bin_index_r <= bin_index;
      result_bin  <= 10'd0;
      found       <= 1'b0;
      status      <= ST_OK;
    end
    case (state)
      S_WAITB: begin
        if (calc_done) begin
          // move walks the old chain, then pushes onto the new one
          wb_r       <= (kind_t'(kind_r) == K_MOVE) ? pbin_rd : BW'(bin_sel);
          nb_r       <= BW'(bin_sel);
          result_bin <= dec_bin;
          status     <= dec_status;
        end
      end
      S_HEAD: begin
        first_r <= 1'b1;
        prev_r  <= CHAIN_END;
      end
      S_STEP: begin
        first_r <= 1'b0;
        if (!walk_hit) prev_r <= cur_w;
        if (walk_end && kind_t'(kind_r) != K_MOVE) status <= ST_NOTFOUND;
        if (walk_hit && kind_t'(kind_r) == K_LOOKUP) begin
          found      <= 1'b1;
          result_bin <= 10'(wb_r);
        end
      end
      S_ULNK: begin
        if (kind_t'(kind_r) == K_REMOVE) begin
          found      <= 1'b1;
          result_bin <= 10'(wb_r);
        end
      end
      S_PUSHW: begin
        result_bin <= 10'(nb_r);
        status     <= ST_OK;
      end
      default: ;
    endcase
  end

  `PCLB_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
  `PCLB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item left block idle")
  `PCLB_ASSERT(a_range_zero, (done && status == ST_RANGE) |-> (result_bin == 10'd0 && !found),
               "range error with nonzero result")
  `PCLB_ASSERT(a_found_ok, (done && found) |-> (status == ST_OK), "found with bad status")
  `PCLB_ASSERT_ALWAYS(a_rst_sweep, rst |=> (busy && !done), "reset did not start sweep")

endmodule
